>>> hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths and constants of the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int PAGE_W   = 16;   // page number width
   localparam int CFG_W    = 5;    // frames_in_use register width
   localparam int FIDX_W   = 4;    // result frame index width
   localparam int UCNT_W   = 16;   // result use count width
   localparam int FAULT_W  = 32;   // fault counter width

   localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
   localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

   typedef logic [PAGE_W-1:0]  page_type;
   typedef logic [CFG_W-1:0]   cfg_type;
   typedef logic [FAULT_W-1:0] fault_type;

endpackage

>>> hdl/lfu_ifs.sv
// ----------------------------------------------------------------------------
// lfu channel interfaces
// Valid/ready channels for page references, results and the register write.
// ----------------------------------------------------------------------------
interface lfu_req_if import lfu_pkg::*; ();
   logic     valid;
   logic     ready;
   page_type page_id;

   modport source (output valid, output page_id, input ready);
   modport sink   (input valid, input page_id, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              hit;
   logic [FIDX_W-1:0] frame_index;
   logic              evicted_valid;
   page_type          evicted_page;
   logic [UCNT_W-1:0] use_count;
   fault_type         fault_total;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output use_count, output fault_total, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input use_count, input fault_total, output ready);
endinterface

interface lfu_csr_if import lfu_pkg::*; ();
   logic    valid;
   logic    ready;
   cfg_type frames_in_use;

   modport source (output valid, output frames_in_use, input ready);
   modport sink   (input valid, input frames_in_use, output ready);
endinterface

>>> hdl/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement
// LFU page replacement: one page reference in, one hit/fill result out.
// ----------------------------------------------------------------------------
// Idle takes a request, scan reads the active frames over the single RAM read
//   port, last compares the final entry, and write commits the frame and loads
//   the result register once it is free. Requests are taken only in idle, also
//   while the previous result still waits in the output register.
// Reset: synchronous, active high; all frames empty, fault count zero,
//   frames_in_use back to 16. No clearing pass, valid bits clear at once.
module lfu_page_replacement import lfu_pkg::*; #(
   parameter int FRAMES     = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   lfu_req_if.sink   req_chan,
   lfu_rsp_if.source rsp_chan,
   lfu_csr_if.sink   csr_chan
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ACT_W = 7;  // holds up to 127 and the 5-bit register value
   localparam logic [ACT_W-1:0]      ACT_MAX   = ACT_W'(FRAMES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_LAST  = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   // ---------------------------------------------------------------- config
   cfg_type cfg_ff;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= CFG_RESET;
      else if (csr_chan.valid) cfg_ff <= csr_chan.frames_in_use;
   end

   // 0 acts as 1, anything above FRAMES acts as FRAMES
   logic [ACT_W-1:0] cfg_wide;
   logic [ACT_W-1:0] act_frames;
   logic [IDX_W-1:0] last_idx;
   assign cfg_wide = ACT_W'(cfg_ff);
   always_comb begin
      priority if (cfg_wide == '0)     act_frames = ACT_W'(1);
      else if     (cfg_wide > ACT_MAX) act_frames = ACT_MAX;
      else                             act_frames = cfg_wide;
   end
   assign last_idx = IDX_W'(act_frames - ACT_W'(1));

   // ---------------------------------------------------------------- table
   logic                  tb_rd_valid;
   page_type              tb_rd_page;
   logic [COUNT_BITS-1:0] tb_rd_count;
   logic                  tb_wr_en;
   logic [IDX_W-1:0]      tb_wr_idx;
   logic [COUNT_BITS-1:0] tb_wr_count;

   logic [1:0]            state_ff,    state_in;
   page_type              page_ff,     page_in;
   logic [IDX_W-1:0]      rd_idx_ff,   rd_idx_in;
   logic [IDX_W-1:0]      last_ff,     last_in;
   logic                  pend_ff;
   logic [IDX_W-1:0]      pend_idx_ff;
   logic                  found_ff,    found_in;
   logic [IDX_W-1:0]      hit_idx_ff,  hit_idx_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff,  hit_cnt_in;
   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic [IDX_W-1:0]      vic_idx_ff,  vic_idx_in;
   logic                  vic_vld_ff,  vic_vld_in;
   page_type              vic_page_ff, vic_page_in;
   fault_type             fault_ff,    fault_in;

   lfu_frame_table #(
      .FRAMES     (FRAMES),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (state_ff == ST_SCAN),
      .rd_idx   (rd_idx_ff),
      .rd_valid (tb_rd_valid),
      .rd_page  (tb_rd_page),
      .rd_count (tb_rd_count),
      .wr_en    (tb_wr_en),
      .wr_idx   (tb_wr_idx),
      .wr_page  (page_ff),
      .wr_count (tb_wr_count)
   );

   // ---------------------------------------------------------------- result reg
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff,   rsp_hit_in;
   logic [FIDX_W-1:0]     rsp_fidx_ff,  rsp_fidx_in;
   logic                  rsp_evv_ff,   rsp_evv_in;
   page_type              rsp_evp_ff,   rsp_evp_in;
   logic [UCNT_W-1:0]     rsp_ucnt_ff,  rsp_ucnt_in;
   fault_type             rsp_fault_ff, rsp_fault_in;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.frame_index   = rsp_fidx_ff;
   assign rsp_chan.evicted_valid = rsp_evv_ff;
   assign rsp_chan.evicted_page  = rsp_evp_ff;
   assign rsp_chan.use_count     = rsp_ucnt_ff;
   assign rsp_chan.fault_total   = rsp_fault_ff;

   // ---------------------------------------------------------------- sequencer
   logic [IDX_W-1:0]      slot;
   logic [COUNT_BITS-1:0] new_cnt;
   logic [31:0]           slot_wide;
   logic [31:0]           cnt_wide;

   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      rd_idx_in    = rd_idx_ff;
      last_in      = last_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_cnt_in   = hit_cnt_ff;
      best_cnt_in  = best_cnt_ff;
      vic_idx_in   = vic_idx_ff;
      vic_vld_in   = vic_vld_ff;
      vic_page_in  = vic_page_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_fidx_in  = rsp_fidx_ff;
      rsp_evv_in   = rsp_evv_ff;
      rsp_evp_in   = rsp_evp_ff;
      rsp_ucnt_in  = rsp_ucnt_ff;
      rsp_fault_in = rsp_fault_ff;
      tb_wr_en     = 1'b0;

      // hit frame or victim, and its count after this reference
      slot    = found_ff ? hit_idx_ff : vic_idx_ff;
      new_cnt = found_ff ? ((hit_cnt_ff == COUNT_MAX) ? hit_cnt_ff : hit_cnt_ff + COUNT_ONE)
                         : COUNT_ONE;
      slot_wide   = 32'(slot);
      cnt_wide    = 32'(new_cnt);
      tb_wr_idx   = slot;
      tb_wr_count = new_cnt;

      // compare the entry read last cycle: first match wins, strict min for victim
      if (pend_ff) begin
         if (!found_ff && tb_rd_valid && tb_rd_page == page_ff) begin
            found_in   = 1'b1;
            hit_idx_in = pend_idx_ff;
            hit_cnt_in = tb_rd_count;
         end
         if (pend_idx_ff == '0 || tb_rd_count < best_cnt_ff) begin
            best_cnt_in = tb_rd_count;
            vic_idx_in  = pend_idx_ff;
            vic_vld_in  = tb_rd_valid;
            vic_page_in = tb_rd_page;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               page_in   = req_chan.page_id;
               last_in   = last_idx;
               rd_idx_in = '0;
               found_in  = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == last_ff) state_in = ST_LAST;
            else rd_idx_in = rd_idx_ff + IDX_W'(1);
         end
         ST_LAST: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // commit only once the result register can take the transfer
            if (out_free) begin
               tb_wr_en = 1'b1;
               if (!found_ff && fault_ff != FAULT_MAX) fault_in = fault_ff + FAULT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_hit_in   = found_ff;
               rsp_fidx_in  = slot_wide[FIDX_W-1:0];
               rsp_evv_in   = !found_ff && vic_vld_ff;
               rsp_evp_in   = (!found_ff && vic_vld_ff) ? vic_page_ff : '0;
               rsp_ucnt_in  = cnt_wide[UCNT_W-1:0];
               rsp_fault_in = (!found_ff && fault_ff != FAULT_MAX) ?
                              fault_ff + FAULT_W'(1) : fault_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= (state_ff == ST_SCAN);
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      rd_idx_ff    <= rd_idx_in;
      last_ff      <= last_in;
      pend_idx_ff  <= rd_idx_ff;
      hit_idx_ff   <= hit_idx_in;
      hit_cnt_ff   <= hit_cnt_in;
      best_cnt_ff  <= best_cnt_in;
      vic_idx_ff   <= vic_idx_in;
      vic_vld_ff   <= vic_vld_in;
      vic_page_ff  <= vic_page_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_fidx_ff  <= rsp_fidx_in;
      rsp_evv_ff   <= rsp_evv_in;
      rsp_evp_ff   <= rsp_evp_in;
      rsp_ucnt_ff  <= rsp_ucnt_in;
      rsp_fault_ff <= rsp_fault_in;
   end

endmodule

>>> hdl/lfu_frame_table.sv
// ----------------------------------------------------------------------------
// lfu_frame_table
// Frame store: page and use count in a synchronous RAM, valid bits in flops.
// An empty frame reads as page 0, count 0.
// ----------------------------------------------------------------------------
module lfu_frame_table import lfu_pkg::*; #(
   parameter int FRAMES     = 16,
   parameter int COUNT_BITS = 16,
   parameter int IDX_W      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_idx,
   output logic                  rd_valid,
   output page_type              rd_page,
   output logic [COUNT_BITS-1:0] rd_count,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_idx,
   input  page_type              wr_page,
   input  logic [COUNT_BITS-1:0] wr_count
);

   page_type              mem_page  [FRAMES];
   logic [COUNT_BITS-1:0] mem_count [FRAMES];
   logic [FRAMES-1:0]     valid_ff;

   page_type              q_page_ff;
   logic [COUNT_BITS-1:0] q_count_ff;
   logic                  q_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_page[wr_idx]  <= wr_page;
         mem_count[wr_idx] <= wr_count;
      end
      if (rd_en) begin
         q_page_ff  <= mem_page[rd_idx];
         q_count_ff <= mem_count[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_idx] <= 1'b1;
         if (rd_en) q_valid_ff <= valid_ff[rd_idx];
      end
   end

   // entries not written since reset are masked to zero
   assign rd_valid = q_valid_ff;
   assign rd_page  = q_valid_ff ? q_page_ff  : '0;
   assign rd_count = q_valid_ff ? q_count_ff : '0;

endmodule

>>> dv/lfu_page_replacement_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_page_replacement_test
// Self-checking bench for the LFU page replacement block. A table of directed
// references and frame-count writes comes first, then random reference streams
// under a series of frame counts, then a back-to-back run on one frame that
// keeps hitting and ends in an eviction. Every result is checked field by
// field against typed-in values or an in-bench LFU table mirror.
// ----------------------------------------------------------------------------
module lfu_page_replacement_test import lfu_pkg::*; ();

   localparam int          TABLE_FRAMES  = 16;
   localparam int          USE_BITS      = 16;
   localparam int unsigned USE_MAX       = (1 << USE_BITS) - 1;
   localparam int          DIRECTED_ROWS = 22;
   localparam int          PHASE_REFS    = 46;
   localparam int          STREAK_REFS   = 40;
   localparam int          HOLD_AT       = 150;     // result number that starts the long hold
   localparam int          HOLD_CYCLES   = 400;
   localparam int          TAIL_CYCLES   = 40;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam page_type    STREAK_PAGE   = 16'hC3A5;
   localparam page_type    EVICTOR_PAGE  = 16'h3C5A;

   // one result transfer, laid out field by field
   typedef struct packed {
      logic              hit;
      logic [FIDX_W-1:0] frame_index;
      logic              evicted_valid;
      page_type          evicted_page;
      logic [UCNT_W-1:0] use_count;
      fault_type         fault_total;
   } page_outcome_type;

   typedef enum logic {ROW_REFERENCE, ROW_FRAMES_WRITE} plan_kind_type;

   typedef struct packed {
      plan_kind_type    kind;
      logic [15:0]      operand;   // page number, or frames_in_use in the low bits
      logic             typed;     // 1: outcome below is the expected result
      page_outcome_type outcome;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   lfu_req_if req_chan ();
   lfu_rsp_if rsp_chan ();
   lfu_csr_if csr_chan ();

   lfu_page_replacement #(
      .FRAMES     (TABLE_FRAMES),
      .COUNT_BITS (USE_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Mirror of the frame table
   // ------------------------------------------------------------------------
   page_type    mirror_page  [TABLE_FRAMES];
   bit          mirror_valid [TABLE_FRAMES];
   int unsigned mirror_uses  [TABLE_FRAMES];
   fault_type   mirror_faults;
   cfg_type     mirror_frames;

   page_outcome_type pending_outcomes [$];   // one per accepted reference, oldest first
   int               failures;
   int               results_seen;
   int unsigned      cycle_count;
   bit               steady;                 // no random gaps or stalls on either side while set
   plan_row_type     directed_plan [DIRECTED_ROWS];

   // Walk the active frames for a match; on a miss take the lowest use count,
   // lowest index on a tie. Empty frames sit at count zero, so they go first.
   function automatic page_outcome_type predict_reference(input page_type pg);
      int unsigned      active;
      int unsigned      slot;
      int unsigned      lowest;
      bit               found;
      page_outcome_type o;
      active = (mirror_frames == 0) ? 1 :
               (mirror_frames > TABLE_FRAMES) ? TABLE_FRAMES : mirror_frames;
      found  = 1'b0;
      slot   = 0;
      o      = '0;
      for (int i = 0; i < active; i++) begin
         if (!found && mirror_valid[i] && mirror_page[i] == pg) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         if (mirror_uses[slot] < USE_MAX) mirror_uses[slot]++;
      end else begin
         lowest = mirror_uses[0];
         for (int i = 1; i < active; i++) begin
            if (mirror_uses[i] < lowest) begin
               lowest = mirror_uses[i];
               slot   = i;
            end
         end
         // an empty victim reports nothing evicted
         if (mirror_valid[slot]) begin
            o.evicted_valid = 1'b1;
            o.evicted_page  = mirror_page[slot];
         end
         mirror_page[slot]  = pg;
         mirror_valid[slot] = 1'b1;
         mirror_uses[slot]  = 1;
         if (mirror_faults != FAULT_MAX) mirror_faults++;
      end
      o.hit         = found;
      o.frame_index = FIDX_W'(slot);
      o.use_count   = UCNT_W'(mirror_uses[slot]);
      o.fault_total = mirror_faults;
      return o;
   endfunction

   // No gap or a short one mostly, now and then a long one; always none while steady.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         failures++;
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Reference sender. Valid stays high into the next transfer when the gap
   // is zero; it is only dropped when a gap follows.
   // ------------------------------------------------------------------------
   task automatic send_page(input page_type pg, input int unsigned gap,
                            input bit given_valid, input page_outcome_type given);
      page_outcome_type predicted;
      req_chan.valid   <= 1'b1;
      req_chan.page_id <= pg;
      do @(posedge clock); while (!req_chan.ready);
      predicted = predict_reference(pg);
      pending_outcomes.push_back(given_valid ? given : predicted);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every expected result has come back.
   task automatic wait_for_idle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   task automatic write_frames(input cfg_type value);
      csr_chan.valid         <= 1'b1;
      csr_chan.frames_in_use <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      mirror_frames  = value;
   endtask

   // ------------------------------------------------------------------------
   // Result receiver: random stalls, plus one long hold so the block backs up
   // and stalls its input while the sender keeps offering.
   // ------------------------------------------------------------------------
   initial begin : result_sink
      int unsigned      stall;
      int unsigned      hold_left;
      page_outcome_type want;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            failures++;
            $error("result transfer with no reference pending");
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("hit", 32'(want.hit), 32'(rsp_chan.hit));
            compare_field("frame_index", 32'(want.frame_index),
                          32'(rsp_chan.frame_index));
            compare_field("evicted_valid", 32'(want.evicted_valid),
                          32'(rsp_chan.evicted_valid));
            compare_field("evicted_page", 32'(want.evicted_page),
                          32'(rsp_chan.evicted_page));
            compare_field("use_count", 32'(want.use_count), 32'(rsp_chan.use_count));
            compare_field("fault_total", 32'(want.fault_total),
                          32'(rsp_chan.fault_total));
         end
         if (results_seen == HOLD_AT) begin
            rsp_chan.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            while (hold_left != 0) begin
               @(posedge clock);
               hold_left--;
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("lfu_page_replacement regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      cfg_type  phase_frames [13];
      page_type pool [$];
      page_type pg;
      int       pool_size;
      int       idx;

      // expectations typed in are read straight off the LFU rules from reset
      directed_plan = '{
         // empty frame holding page 0 must not match page 0
         '{ROW_REFERENCE,    16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd1, 32'd1}},
         '{ROW_REFERENCE,    16'hFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 16'd1, 32'd2}},
         '{ROW_REFERENCE,    16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd2, 32'd2}},
         '{ROW_REFERENCE,    16'hFFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 16'd2, 32'd2}},
         '{ROW_FRAMES_WRITE, 16'd2,    1'b0, '0},
         // tie at count 2: lowest index loses its page
         '{ROW_REFERENCE,    16'h1234, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0000, 16'd1, 32'd3}},
         '{ROW_REFERENCE,    16'h0000, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h1234, 16'd1, 32'd4}},
         // zero frames acts as one; frame 1 keeps 0xFFFF but is out of reach
         '{ROW_FRAMES_WRITE, 16'd0,    1'b0, '0},
         '{ROW_REFERENCE,    16'hFFFF, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0000, 16'd1, 32'd5}},
         // above the frame count acts as all frames; first match wins
         '{ROW_FRAMES_WRITE, 16'd31,   1'b0, '0},
         '{ROW_REFERENCE,    16'hFFFF, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd2, 32'd5}},
         '{ROW_REFERENCE,    16'h8000, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 16'd1, 32'd6}},
         '{ROW_FRAMES_WRITE, 16'd16,   1'b0, '0},
         '{ROW_REFERENCE,    16'h7FFF, 1'b0, '0},
         '{ROW_REFERENCE,    16'h5555, 1'b0, '0},
         '{ROW_REFERENCE,    16'hAAAA, 1'b0, '0},
         '{ROW_REFERENCE,    16'h8000, 1'b0, '0},
         '{ROW_FRAMES_WRITE, 16'd1,    1'b0, '0},
         '{ROW_REFERENCE,    16'h0001, 1'b0, '0},
         '{ROW_FRAMES_WRITE, 16'd17,   1'b0, '0},
         '{ROW_REFERENCE,    16'hFFFE, 1'b0, '0},
         '{ROW_REFERENCE,    16'h0001, 1'b0, '0}
      };
      // frame counts walked by the random part, shrinking and growing
      phase_frames = '{5'd16, 5'd1, 5'd3, 5'd17, 5'd0, 5'd8, 5'd31, 5'd2,
                       5'd5, 5'd16, 5'd12, 5'd1, 5'd16};

      failures     = 0;
      results_seen = 0;
      steady       = 1'b0;

      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.page_id       <= '0;
      csr_chan.valid         <= 1'b0;
      csr_chan.frames_in_use <= CFG_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (mirror_page[i]) begin
         mirror_page[i]  = '0;
         mirror_valid[i] = 1'b0;
         mirror_uses[i]  = 0;
      end
      mirror_faults = '0;
      mirror_frames = CFG_RESET;

      // directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_plan[r].kind == ROW_FRAMES_WRITE) begin
            wait_for_idle();
            write_frames(CFG_W'(directed_plan[r].operand));
         end else begin
            send_page(directed_plan[r].operand, pick_gap(),
                      directed_plan[r].typed, directed_plan[r].outcome);
         end
      end

      // random streams: mostly a skewed working set a little larger than the
      // active frames, so hits, ties and evictions all show up; the rest is
      // full-range noise that toggles every page bit
      foreach (phase_frames[p]) begin
         wait_for_idle();
         write_frames(phase_frames[p]);
         steady    = (p % 4 == 2);
         pool_size = ((phase_frames[p] == 0) ? 1 : phase_frames[p] > TABLE_FRAMES ?
                      TABLE_FRAMES : phase_frames[p]) + $urandom_range(0, 4);
         pool.delete();
         repeat (pool_size) pool.push_back(page_type'($urandom_range(0, 65535)));
         repeat (PHASE_REFS) begin
            if ($urandom_range(0, 99) < 85) begin
               idx = $urandom_range(0, pool_size - 1);
               idx = (idx < $urandom_range(0, pool_size - 1)) ? idx :
                     $urandom_range(0, pool_size - 1);
               pg  = pool[idx];
            end else begin
               pg = page_type'($urandom_range(0, 65535));
            end
            send_page(pg, pick_gap(), 1'b0, '0);
         end
      end

      // one frame, back to back: the use count climbs with every hit, then a
      // new page evicts the busy frame
      wait_for_idle();
      write_frames(5'd1);
      steady = 1'b1;
      repeat (STREAK_REFS) send_page(STREAK_PAGE, 0, 1'b0, '0);
      send_page(EVICTOR_PAGE, 1, 1'b0, '0);
      steady = 1'b0;

      wait_for_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         failures++;
         $error("%0d expected results never arrived", pending_outcomes.size());
      end
      if (failures == 0)
         $display("lfu_page_replacement regression: pass");
      else
         $display("lfu_page_replacement regression: fail");
      $finish;
   end

endmodule

>>> files.f
hdl/lfu_pkg.sv
hdl/lfu_ifs.sv
hdl/lfu_frame_table.sv
hdl/lfu_page_replacement.sv
dv/lfu_page_replacement_test.sv
